>>> src/green_gauss_gradient_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Green-Gauss gradient accumulator: assertion macros
// Concurrent checks used by the block's RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GREEN_GAUSS_GRADIENT_ACCUMULATOR_DEFINES_SVH
`define GREEN_GAUSS_GRADIENT_ACCUMULATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define GGA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GGA_NEVER(lbl, clk, rst, cond, msg) \
  `GGA_ASSERT(lbl, clk, rst, !(cond), msg)
`else
`define GGA_ASSERT(lbl, clk, rst, prop, msg)
`define GGA_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> src/gga_pkg.sv
// ----------------------------------------------------------------------------
// gga_pkg
// Types, constants and helpers of the Green-Gauss gradient accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package gga_pkg;

  localparam int ACC_W  = 48;
  localparam int MUL_W  = 34;
  localparam int PROD_W = 68;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [16:0]      W_ONE   = 17'h10000;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_FACE  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISP, S_LOAD,
    S_F_RA, S_F_RB, S_F_VB, S_F_MW, S_F_PHI,
    S_F_MN, S_F_T, S_F_MA, S_F_FL,
    S_F_ARA, S_F_AWA, S_F_ARB, S_F_AWB,
    S_R_RD, S_R_LD, S_R_DS, S_R_DW, S_R_EMIT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic        ovf;
    logic [31:0] quot;
  } div_rsp_t;

  // |x| / 2^s rounded half away from zero
  function automatic logic [PROD_W-1:0] rnd_mag(input logic [PROD_W-1:0] x,
                                                input logic [4:0] s);
    logic [PROD_W-1:0] m;
    m = x[PROD_W-1] ? (~x + 1'b1) : x;
    return (m + (PROD_W'(1) << (s - 5'd1))) >> s;
  endfunction

  // signed 48-bit add or subtract, saturating
  function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b,
                                               input logic sub);
    logic [ACC_W:0] s;
    s = sub ? ({a[ACC_W-1], a} - {b[ACC_W-1], b}) : ({a[ACC_W-1], a} + {b[ACC_W-1], b});
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/gga_if.sv
// ----------------------------------------------------------------------------
// gga_if
// Request, result and configuration channels of the gradient accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

interface gga_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  cell_a;
  logic [9:0]  cell_b;
  logic [2:0]  var_index;
  logic [31:0] cell_value;
  logic [16:0] weight;
  logic [15:0] normal_x;
  logic [15:0] normal_y;
  logic [15:0] normal_z;
  logic [31:0] face_area;
  logic [31:0] volume;
  modport source (output valid, opcode, cell_a, cell_b, var_index, cell_value, weight,
                  normal_x, normal_y, normal_z, face_area, volume, input ready);
  modport sink (input valid, opcode, cell_a, cell_b, var_index, cell_value, weight,
                normal_x, normal_y, normal_z, face_area, volume, output ready);
endinterface

interface gga_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] grad_x;
  logic [31:0] grad_y;
  logic [31:0] grad_z;
  logic [9:0]  out_cell;
  logic [2:0]  out_var;
  logic        last;
  modport source (output valid, grad_x, grad_y, grad_z, out_cell, out_var, last,
                  input ready);
  modport sink (input valid, grad_x, grad_y, grad_z, out_cell, out_var, last,
                output ready);
endinterface

interface gga_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

>>> src/gga_ram.sv
// ----------------------------------------------------------------------------
// gga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/gga_div.sv
// ----------------------------------------------------------------------------
// gga_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// Flags overflow when the quotient does not fit in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module gga_div (
  input  logic              clk,
  input  logic              rst,
  input  gga_pkg::div_req_t req,
  output gga_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic        ovf;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] lo;
  logic [31:0] quot;
  logic [32:0] trial;

  // shift in next dividend bit
  assign trial = {rem, lo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ovf  <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= '0;
        if (req.num[63:32] >= req.den) begin
          done <= 1'b1;
          ovf  <= 1'b1;
        end else begin
          busy <= 1'b1;
          ovf  <= 1'b0;
          rem  <= req.num[63:32];
          lo   <= req.num[31:0];
        end
      end else if (busy) begin
        if (trial >= {1'b0, req.den}) begin
          rem  <= 32'(trial - {1'b0, req.den});
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem  <= trial[31:0];
          quot <= {quot[30:0], 1'b0};
        end
        lo  <= {lo[30:0], 1'b0};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, ovf: ovf, quot: quot};

endmodule

`default_nettype wire

>>> src/green_gauss_gradient_accumulator.sv
// ----------------------------------------------------------------------------
// green_gauss_gradient_accumulator
// A load writes one value; a face updates both cells for each active variable;
//   a readout divides each accumulator by the volume (32-step divider pass), with
//   no pass on quotient overflow or when zero; a stalled result holds the readout.
// Clear sweeps one accumulator row per cycle.
// One request at a time; the shared multiplier and divider set the rate.
// Reset runs the same clearing pass; num_vars = 1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "green_gauss_gradient_accumulator_defines.svh"

module green_gauss_gradient_accumulator #(
  parameter int MAX_CELLS = 1024,
  parameter int MAX_VARS  = 8
) (
  input  logic             clk,
  input  logic             rst,
  gga_cfg_if.sink          cfg,
  gga_item_if.sink         item,
  gga_result_if.source     result
);

  localparam int DEPTH  = MAX_CELLS * MAX_VARS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int J_W    = $clog2(MAX_VARS + 1);
  localparam int ACC_W  = gga_pkg::ACC_W;
  localparam int PROD_W = gga_pkg::PROD_W;
  localparam int MUL_W  = gga_pkg::MUL_W;

  gga_pkg::state_t state, state_next;

  logic [3:0]  num_vars;
  logic [1:0]  op;
  logic [9:0]  cell_a;
  logic [9:0]  cell_b;
  logic [2:0]  var_idx;
  logic [31:0] value;
  logic [16:0] weight;
  logic [15:0] nrm [3];
  logic [31:0] area;
  logic [31:0] volume;

  logic [J_W-1:0]    j;
  logic [1:0]        k;
  logic [ADDR_W-1:0] clr_addr;
  logic [31:0]       va, vb, phi;
  logic [32:0]       tmag;
  logic              tneg;
  logic [ACC_W-1:0]  flux [3];
  logic [ACC_W-1:0]  acc_r [3];
  logic [31:0]       grad [3];
  logic signed [PROD_W-1:0] prod;

  logic        res_valid;
  logic [31:0] res_gx, res_gy, res_gz;
  logic [9:0]  res_cell;
  logic [2:0]  res_var;
  logic        res_last;

  logic [J_W-1:0]    nv;
  logic              last_var;
  logic              ca_ok, cb_ok, ld_ok;
  logic [ADDR_W-1:0] ia, ib, il;

  logic              val_we;
  logic [ADDR_W-1:0] val_raddr;
  logic [31:0]       val_rdata;
  logic              acc_we;
  logic [ADDR_W-1:0] acc_waddr, acc_raddr;
  logic [3*ACC_W-1:0] acc_wdata, acc_rdata;
  logic [ACC_W-1:0]  acc_rd [3];

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] rnd16, rnd14;
  logic [PROD_W-1:0] phi_off;
  logic [ACC_W-1:0]  fl_val;
  logic [ACC_W-1:0]  acc_sel, acc_mag;
  logic [31:0]       gr_val;
  logic              emit;

  gga_pkg::div_req_t div_req;
  gga_pkg::div_rsp_t div_rsp;

  // active variable count, clamped
  always_comb begin
    if (num_vars == 4'd0) begin
      nv = J_W'(1);
    end else if (int'(num_vars) > MAX_VARS) begin
      nv = J_W'(MAX_VARS);
    end else begin
      nv = J_W'(num_vars);
    end
  end

  assign last_var = (j == nv - J_W'(1));
  assign ca_ok    = int'(cell_a) < MAX_CELLS;
  assign cb_ok    = int'(cell_b) < MAX_CELLS;
  assign ld_ok    = ca_ok && (int'(var_idx) < MAX_VARS);
  assign ia       = ADDR_W'(int'(cell_a) * MAX_VARS + int'(j));
  assign ib       = ADDR_W'(int'(cell_b) * MAX_VARS + int'(j));
  assign il       = ADDR_W'(int'(cell_a) * MAX_VARS + int'(var_idx));

  // storage
  gga_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (il),
    .wdata (value),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  gga_ram #(.WIDTH(3*ACC_W), .DEPTH(DEPTH)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  assign acc_rd[0] = acc_rdata[ACC_W-1:0];
  assign acc_rd[1] = acc_rdata[2*ACC_W-1:ACC_W];
  assign acc_rd[2] = acc_rdata[3*ACC_W-1:2*ACC_W];

  gga_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // rounding of the registered product
  assign rnd16   = gga_pkg::rnd_mag(prod, 5'd16);
  assign rnd14   = gga_pkg::rnd_mag(prod, 5'd14);
  assign phi_off = prod[PROD_W-1] ? (~rnd16 + 1'b1) : rnd16;

  // flux magnitude with sign and 48-bit saturation
  always_comb begin
    if (tneg) begin
      fl_val = (rnd16 > PROD_W'(gga_pkg::ACC_MAX) + PROD_W'(1)) ? gga_pkg::ACC_MIN
                                                               : ACC_W'(~rnd16 + 1'b1);
    end else begin
      fl_val = (rnd16 > PROD_W'(gga_pkg::ACC_MAX)) ? gga_pkg::ACC_MAX : ACC_W'(rnd16);
    end
  end

  // readout divider operands and result formatting
  assign acc_sel = acc_r[k];
  assign acc_mag = acc_sel[ACC_W-1] ? (~acc_sel + 1'b1) : acc_sel;

  always_comb begin
    if (div_rsp.ovf) begin
      gr_val = acc_sel[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (acc_sel[ACC_W-1]) begin
      gr_val = div_rsp.quot[31] ? 32'h8000_0000 : (~div_rsp.quot + 32'd1);
    end else begin
      gr_val = div_rsp.quot[31] ? 32'h7FFF_FFFF : div_rsp.quot;
    end
  end

  assign div_req.start = (state == gga_pkg::S_R_DS) && (acc_mag != '0);
  assign div_req.num   = {acc_mag, 16'd0} + {33'd0, volume[31:1]};
  assign div_req.den   = volume;

  assign emit = (state == gga_pkg::S_R_EMIT) && (!res_valid || result.ready);

  // sequencer: next state, memory control and multiplier operands
  always_comb begin
    state_next = state;
    val_we     = 1'b0;
    val_raddr  = ia;
    acc_we     = 1'b0;
    acc_waddr  = ia;
    acc_wdata  = '0;
    acc_raddr  = ia;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      gga_pkg::S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
        if (int'(clr_addr) == DEPTH - 1) begin
          state_next = gga_pkg::S_IDLE;
        end
      end
      gga_pkg::S_IDLE: begin
        if (item.valid) begin
          state_next = gga_pkg::S_DISP;
        end
      end
      gga_pkg::S_DISP: begin
        unique case (gga_pkg::opcode_t'(op))
          gga_pkg::OP_CLEAR: state_next = gga_pkg::S_CLEAR;
          gga_pkg::OP_LOAD:  state_next = gga_pkg::S_LOAD;
          gga_pkg::OP_FACE:  state_next = (ca_ok && cb_ok) ? gga_pkg::S_F_RA : gga_pkg::S_IDLE;
          gga_pkg::OP_READ:  state_next = gga_pkg::S_R_RD;
        endcase
      end
      gga_pkg::S_LOAD: begin
        val_we     = ld_ok;
        state_next = gga_pkg::S_IDLE;
      end
      gga_pkg::S_F_RA:  state_next = gga_pkg::S_F_RB;
      gga_pkg::S_F_RB: begin
        val_raddr  = ib;
        state_next = gga_pkg::S_F_VB;
      end
      gga_pkg::S_F_VB:  state_next = gga_pkg::S_F_MW;
      gga_pkg::S_F_MW: begin
        mul_a      = MUL_W'(signed'(vb)) - MUL_W'(signed'(va));
        mul_b      = signed'(MUL_W'(weight));
        state_next = gga_pkg::S_F_PHI;
      end
      gga_pkg::S_F_PHI: state_next = gga_pkg::S_F_MN;
      gga_pkg::S_F_MN: begin
        mul_a      = MUL_W'(signed'(phi));
        mul_b      = MUL_W'(signed'(nrm[k]));
        state_next = gga_pkg::S_F_T;
      end
      gga_pkg::S_F_T:   state_next = gga_pkg::S_F_MA;
      gga_pkg::S_F_MA: begin
        mul_a      = signed'(MUL_W'(tmag));
        mul_b      = signed'(MUL_W'(area));
        state_next = gga_pkg::S_F_FL;
      end
      gga_pkg::S_F_FL: begin
        state_next = (k == 2'd2) ? gga_pkg::S_F_ARA : gga_pkg::S_F_MN;
      end
      gga_pkg::S_F_ARA: state_next = gga_pkg::S_F_AWA;
      gga_pkg::S_F_AWA: begin
        acc_we     = 1'b1;
        acc_wdata  = {gga_pkg::acc_sat(acc_rd[2], flux[2], 1'b0),
                      gga_pkg::acc_sat(acc_rd[1], flux[1], 1'b0),
                      gga_pkg::acc_sat(acc_rd[0], flux[0], 1'b0)};
        state_next = gga_pkg::S_F_ARB;
      end
      gga_pkg::S_F_ARB: begin
        acc_raddr  = ib;
        state_next = gga_pkg::S_F_AWB;
      end
      gga_pkg::S_F_AWB: begin
        acc_we     = 1'b1;
        acc_waddr  = ib;
        acc_wdata  = {gga_pkg::acc_sat(acc_rd[2], flux[2], 1'b1),
                      gga_pkg::acc_sat(acc_rd[1], flux[1], 1'b1),
                      gga_pkg::acc_sat(acc_rd[0], flux[0], 1'b1)};
        state_next = last_var ? gga_pkg::S_IDLE : gga_pkg::S_F_RA;
      end
      gga_pkg::S_R_RD:  state_next = gga_pkg::S_R_LD;
      gga_pkg::S_R_LD:  state_next = gga_pkg::S_R_DS;
      gga_pkg::S_R_DS: begin
        if (div_req.start) begin
          state_next = gga_pkg::S_R_DW;
        end else if (k == 2'd2) begin
          state_next = gga_pkg::S_R_EMIT;
        end
      end
      gga_pkg::S_R_DW: begin
        if (div_rsp.done) begin
          state_next = (k == 2'd2) ? gga_pkg::S_R_EMIT : gga_pkg::S_R_DS;
        end
      end
      gga_pkg::S_R_EMIT: begin
        if (emit) begin
          state_next = last_var ? gga_pkg::S_IDLE : gga_pkg::S_R_RD;
        end
      end
      default: state_next = gga_pkg::S_IDLE;
    endcase
  end

  // state register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gga_pkg::S_CLEAR;
      num_vars  <= 4'd1;
      clr_addr  <= '0;
      j         <= '0;
      k         <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        num_vars <= cfg.data;
      end
      // clearing sweep address
      if (state == gga_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end else begin
        clr_addr <= '0;
      end
      // variable and component counters
      priority if (state == gga_pkg::S_DISP) begin
        j <= '0;
        k <= '0;
      end else if (state == gga_pkg::S_F_FL) begin
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end else if (state == gga_pkg::S_F_AWB) begin
        j <= j + J_W'(1);
      end else if ((state == gga_pkg::S_R_DS && !div_req.start) ||
                   (state == gga_pkg::S_R_DW && div_rsp.done)) begin
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end else if (emit) begin
        j <= j + J_W'(1);
      end
      // result register
      if (emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (item.valid && item.ready) begin
      op      <= item.opcode;
      cell_a  <= item.cell_a;
      cell_b  <= item.cell_b;
      var_idx <= item.var_index;
      value   <= item.cell_value;
      weight  <= (item.weight > gga_pkg::W_ONE) ? gga_pkg::W_ONE : item.weight;
      nrm[0]  <= item.normal_x;
      nrm[1]  <= item.normal_y;
      nrm[2]  <= item.normal_z;
      area    <= item.face_area;
      volume  <= item.volume;
    end
    if (state == gga_pkg::S_F_RB) begin
      va <= val_rdata;
    end
    if (state == gga_pkg::S_F_VB) begin
      vb <= val_rdata;
    end
    if (state == gga_pkg::S_F_PHI) begin
      phi <= 32'(phi_off + PROD_W'(signed'(va)));
    end
    if (state == gga_pkg::S_F_T) begin
      tmag <= 33'(rnd14);
      tneg <= prod[PROD_W-1];
    end
    if (state == gga_pkg::S_F_FL) begin
      flux[k] <= fl_val;
    end
    if (state == gga_pkg::S_R_LD) begin
      acc_r[0] <= ca_ok ? acc_rd[0] : '0;
      acc_r[1] <= ca_ok ? acc_rd[1] : '0;
      acc_r[2] <= ca_ok ? acc_rd[2] : '0;
    end
    if (state == gga_pkg::S_R_DS && !div_req.start) begin
      grad[k] <= '0;
    end
    if (state == gga_pkg::S_R_DW && div_rsp.done) begin
      grad[k] <= gr_val;
    end
    if (emit) begin
      res_gx   <= grad[0];
      res_gy   <= grad[1];
      res_gz   <= grad[2];
      res_cell <= cell_a;
      res_var  <= 3'(j);
      res_last <= last_var;
    end
  end

  // ports
  assign item.ready      = (state == gga_pkg::S_IDLE);
  assign cfg.ready       = 1'b1;
  assign result.valid    = res_valid;
  assign result.grad_x   = res_gx;
  assign result.grad_y   = res_gy;
  assign result.grad_z   = res_gz;
  assign result.out_cell = res_cell;
  assign result.out_var  = res_var;
  assign result.last     = res_last;

  // checks
  `GGA_ASSERT(a_acc_we_busy, clk, rst, acc_we |-> state != gga_pkg::S_IDLE, "accumulator write while idle")
  `GGA_ASSERT(a_emit_src, clk, rst, $rose(res_valid) |-> $past(state) == gga_pkg::S_R_EMIT, "result loaded outside emit")
  `GGA_ASSERT(a_div_wait, clk, rst, div_rsp.done |-> state == gga_pkg::S_R_DW, "divider done while not waiting")
  `GGA_NEVER(a_div_idle, clk, rst, div_rsp.busy && state == gga_pkg::S_IDLE, "divider busy while idle")

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: Green-Gauss gradient accumulator testbench
// Drives loads, faces, readouts and clears through the request channel and
// checks every gradient result against a cycle-free predictor of the
// accumulators, under random gaps on both channels and several variable counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int NCELLS = 1024;
  localparam int NVARS = 8;
  localparam int DEPTH = NCELLS * NVARS;
  localparam int STALL_LIMIT = 40000;
  localparam int CLEAR_WAIT = 9000;
  localparam longint SAT_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SAT_LO = -SAT_HI - 1;

  typedef struct {
    gga_pkg::opcode_t op;
    logic [9:0]  ca;
    logic [9:0]  cb;
    logic [2:0]  vi;
    logic [31:0] val;
    logic [16:0] w;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic [31:0] area;
    logic [31:0] vol;
  } gga_request_t;

  typedef struct {
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] gz;
    logic [9:0]  cell_id;
    logic [2:0]  vr;
    logic        last;
  } grad_result_t;

  logic clk;
  logic rst;

  gga_item_if   item_ch ();
  gga_result_if res_ch ();
  gga_cfg_if    cfg_ch ();

  green_gauss_gradient_accumulator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  // predictor state
  logic [3:0]         var_count;
  logic signed [31:0] cell_vals [DEPTH];
  bit                 cell_loaded [DEPTH];
  longint             grad_acc_x [DEPTH];
  longint             grad_acc_y [DEPTH];
  longint             grad_acc_z [DEPTH];
  grad_result_t       pending_grads [$];

  int  errors = 0;
  int  n_load, n_face, n_read, n_clear, n_checked;
  bit  quiet;
  int  res_stall = 0;
  int  idle_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint round_shift(longint x, int s);
    longint unsigned m;
    m = (x < 0) ? longint'(-x) : x;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp48(longint x);
    if (x > SAT_HI) return SAT_HI;
    if (x < SAT_LO) return SAT_LO;
    return x;
  endfunction

  function automatic longint face_flux(longint t, longint unsigned area);
    longint unsigned m, hi, lo, r;
    m = (t < 0) ? longint'(-t) : t;
    hi = m * (area >> 16);
    lo = (m * (area & 64'hFFFF) + 64'h8000) >> 16;
    r = hi + lo;
    if (t < 0) return (r > longint'(SAT_HI) + 1) ? SAT_LO : -longint'(r);
    return (r > SAT_HI) ? SAT_HI : longint'(r);
  endfunction

  function automatic logic [31:0] cell_gradient(longint acc, longint unsigned vol);
    longint unsigned m, q;
    m = (acc < 0) ? longint'(-acc) : acc;
    if (m == 0) return 32'd0;
    if (vol == 0) q = 64'hFFFF_FFFF_FFFF_FFFF;
    else q = ((m << 16) + (vol >> 1)) / vol;
    if (acc < 0) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic int used_vars();
    if (var_count == 0) return 1;
    if (var_count > NVARS) return NVARS;
    return int'(var_count);
  endfunction

  // apply one accepted request to the shadow state
  task automatic update_gradients(gga_request_t r);
    int nv, ia, ib;
    longint va, vb, phi, fx, fy, fz;
    longint w;
    grad_result_t g;
    nv = used_vars();
    case (r.op)
      gga_pkg::OP_CLEAR: begin
        n_clear++;
        for (int i = 0; i < DEPTH; i++) begin
          grad_acc_x[i] = 0;
          grad_acc_y[i] = 0;
          grad_acc_z[i] = 0;
        end
      end
      gga_pkg::OP_LOAD: begin
        n_load++;
        cell_vals[r.ca * NVARS + r.vi] = r.val;
        cell_loaded[r.ca * NVARS + r.vi] = 1'b1;
      end
      gga_pkg::OP_FACE: begin
        n_face++;
        w = (r.w > gga_pkg::W_ONE) ? longint'(gga_pkg::W_ONE) : longint'(r.w);
        for (int j = 0; j < nv; j++) begin
          ia = r.ca * NVARS + j;
          ib = r.cb * NVARS + j;
          va = longint'(cell_vals[ia]);
          vb = longint'(cell_vals[ib]);
          phi = va + round_shift((vb - va) * w, 16);
          fx = face_flux(round_shift(phi * longint'(signed'(r.nx)), 14), 64'(r.area));
          fy = face_flux(round_shift(phi * longint'(signed'(r.ny)), 14), 64'(r.area));
          fz = face_flux(round_shift(phi * longint'(signed'(r.nz)), 14), 64'(r.area));
          grad_acc_x[ia] = clamp48(grad_acc_x[ia] + fx);
          grad_acc_y[ia] = clamp48(grad_acc_y[ia] + fy);
          grad_acc_z[ia] = clamp48(grad_acc_z[ia] + fz);
          grad_acc_x[ib] = clamp48(grad_acc_x[ib] - fx);
          grad_acc_y[ib] = clamp48(grad_acc_y[ib] - fy);
          grad_acc_z[ib] = clamp48(grad_acc_z[ib] - fz);
        end
      end
      default: begin
        n_read++;
        for (int j = 0; j < nv; j++) begin
          ia = r.ca * NVARS + j;
          g.gx = cell_gradient(grad_acc_x[ia], 64'(r.vol));
          g.gy = cell_gradient(grad_acc_y[ia], 64'(r.vol));
          g.gz = cell_gradient(grad_acc_z[ia], 64'(r.vol));
          g.cell_id = r.ca;
          g.vr = j[2:0];
          g.last = (j + 1 == nv);
          pending_grads.push_back(g);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // request driver: called at a clock edge, returns at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_request(gga_request_t r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.opcode     <= r.op;
    item_ch.cell_a     <= r.ca;
    item_ch.cell_b     <= r.cb;
    item_ch.var_index  <= r.vi;
    item_ch.cell_value <= r.val;
    item_ch.weight     <= r.w;
    item_ch.normal_x   <= r.nx;
    item_ch.normal_y   <= r.ny;
    item_ch.normal_z   <= r.nz;
    item_ch.face_area  <= r.area;
    item_ch.volume     <= r.vol;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    update_gradients(r);
  endtask

  function automatic gga_request_t noise_request(gga_pkg::opcode_t op);
    gga_request_t r;
    r.op = op;
    r.ca = 10'($urandom);
    r.cb = 10'($urandom);
    r.vi = 3'($urandom);
    r.val = $urandom;
    r.w = 17'($urandom);
    r.nx = 16'($urandom);
    r.ny = 16'($urandom);
    r.nz = 16'($urandom);
    r.area = $urandom;
    r.vol = $urandom;
    return r;
  endfunction

  task automatic load_value(int cell_no, int vr, logic [31:0] v);
    gga_request_t r;
    r = noise_request(gga_pkg::OP_LOAD);
    r.ca = 10'(cell_no);
    r.vi = 3'(vr);
    r.val = v;
    send_request(r);
  endtask

  task automatic face_request(int a, int b, logic [16:0] w, logic [15:0] nx,
                              logic [15:0] ny, logic [15:0] nz, logic [31:0] area);
    gga_request_t r;
    r = noise_request(gga_pkg::OP_FACE);
    r.ca = 10'(a);
    r.cb = 10'(b);
    r.w = w;
    r.nx = nx;
    r.ny = ny;
    r.nz = nz;
    r.area = area;
    send_request(r);
  endtask

  task automatic read_cell(int cell_no, logic [31:0] vol);
    gga_request_t r;
    r = noise_request(gga_pkg::OP_READ);
    r.ca = 10'(cell_no);
    r.vol = vol;
    send_request(r);
  endtask

  // wait for all results, then for a trailing clear or face to finish
  task automatic drain_and_settle();
    item_ch.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic write_var_count(logic [3:0] n);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    var_count = n;
  endtask

  function automatic bit face_ready(int a, int b);
    for (int j = 0; j < used_vars(); j++) begin
      if (!cell_loaded[a * NVARS + j] || !cell_loaded[b * NVARS + j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // extremes: full-scale values, saturating flux, weight above one,
  // one-cell face, zero volume, untouched cell, clear
  task automatic test_directed();
    write_var_count(4'd8);
    for (int j = 0; j < NVARS; j++) begin
      load_value(0, j, (j == 0) ? 32'h7FFF_FFFF : (j == 1) ? 32'h8000_0000 :
                       (j == 2) ? 32'h0 : (j == 3) ? 32'h0001_0000 : $urandom);
      load_value(1023, j, (j == 0) ? 32'h8000_0000 : (j == 1) ? 32'h7FFF_FFFF :
                          (j == 2) ? 32'hFFFF_0000 : $urandom);
    end
    face_request(0, 1023, 17'd0, 16'sd16384, -16'sd16384, 16'd0, 32'hFFFF_FFFF);
    face_request(0, 1023, 17'h1FFFF, -16'sd16384, 16'sd16384, 16'h7FFF, 32'hFFFF_FFFF);
    face_request(0, 0, 17'h10000, 16'sd16384, 16'h8000, 16'sd8192, 32'h0001_0000);
    read_cell(0, 32'd0);
    read_cell(1023, 32'd1);
    read_cell(1023, 32'hFFFF_FFFF);
    read_cell(5, 32'd0);
    read_cell(0, 32'h0001_0000);
    send_request(noise_request(gga_pkg::OP_CLEAR));
    read_cell(0, 32'h0000_8000);
  endtask

  // random traffic over a small pool of cells
  task automatic test_random(logic [3:0] nv, int count);
    int pool [12] = '{0, 1, 2, 3, 4, 5, 6, 7, 511, 512, 1022, 1023};
    gga_request_t r;
    int pick, a, b;
    drain_and_settle();
    write_var_count(nv);
    for (int i = 0; i < count; i++) begin
      if (i % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      a = pool[$urandom_range(0, 11)];
      b = pool[$urandom_range(0, 11)];
      if (pick < 2) begin
        send_request(noise_request(gga_pkg::OP_CLEAR));
      end else if (pick < 30) begin
        r = noise_request(gga_pkg::OP_LOAD);
        r.ca = 10'(a);
        if ($urandom_range(0, 2) == 0) r.val = $urandom_range(0, 8'hFF) << 16;
        send_request(r);
      end else if (pick < 72) begin
        if (!face_ready(a, b)) begin
          // fill one missing entry instead
          for (int j = 0; j < used_vars(); j++) begin
            if (!cell_loaded[a * NVARS + j]) b = a;
            if (!cell_loaded[b * NVARS + j]) begin
              load_value(b, j, $urandom);
              break;
            end
          end
        end else begin
          r = noise_request(gga_pkg::OP_FACE);
          r.ca = 10'(a);
          r.cb = ($urandom_range(0, 9) == 0) ? 10'(a) : 10'(b);
          r.w = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
          if ($urandom_range(0, 3) != 0) begin
            r.nx = 16'($urandom_range(0, 32768) - 16384);
            r.ny = 16'($urandom_range(0, 32768) - 16384);
            r.nz = 16'($urandom_range(0, 32768) - 16384);
          end
          if ($urandom_range(0, 5) != 0) r.area = $urandom_range(0, 32'h3_FFFF);
          send_request(r);
        end
      end else begin
        r = noise_request(gga_pkg::OP_READ);
        r.ca = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) : 10'(a);
        case ($urandom_range(0, 5))
          0: r.vol = 32'd0;
          1: r.vol = $urandom_range(1, 16);
          2: r.vol = $urandom_range(32'h8000, 32'h4_0000);
          default: r.vol = $urandom;
        endcase
        send_request(r);
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // result checker with random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    grad_result_t e;
    if (!rst && res_ch.valid && res_ch.ready) begin
      n_checked++;
      if (pending_grads.size() == 0) begin
        $error("unexpected result: cell %0d var %0d", res_ch.out_cell, res_ch.out_var);
        errors++;
      end else begin
        e = pending_grads.pop_front();
        if (res_ch.grad_x !== e.gx) begin
          $error("grad_x: expected %h, got %h", e.gx, res_ch.grad_x);
          errors++;
        end
        if (res_ch.grad_y !== e.gy) begin
          $error("grad_y: expected %h, got %h", e.gy, res_ch.grad_y);
          errors++;
        end
        if (res_ch.grad_z !== e.gz) begin
          $error("grad_z: expected %h, got %h", e.gz, res_ch.grad_z);
          errors++;
        end
        if (res_ch.out_cell !== e.cell_id) begin
          $error("out_cell: expected %0d, got %0d", e.cell_id, res_ch.out_cell);
          errors++;
        end
        if (res_ch.out_var !== e.vr) begin
          $error("out_var: expected %0d, got %0d", e.vr, res_ch.out_var);
          errors++;
        end
        if (res_ch.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, res_ch.last);
          errors++;
        end
      end
      res_stall = quiet ? 0 : $urandom_range(0, 18);
    end
    if (res_stall > 0) begin
      res_ch.ready <= 1'b0;
      res_stall--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL green_gauss_gradient_accumulator");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.opcode = gga_pkg::OP_CLEAR;
    item_ch.cell_a = '0;
    item_ch.cell_b = '0;
    item_ch.var_index = '0;
    item_ch.cell_value = '0;
    item_ch.weight = '0;
    item_ch.normal_x = '0;
    item_ch.normal_y = '0;
    item_ch.normal_z = '0;
    item_ch.face_area = '0;
    item_ch.volume = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    var_count = 4'd1;
    quiet = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      cell_loaded[i] = 1'b0;
      cell_vals[i] = 0;
      grad_acc_x[i] = 0;
      grad_acc_y[i] = 0;
      grad_acc_z[i] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(4'd1, 45);
    test_random(4'd0, 20);
    test_random(4'd15, 40);
    test_random(4'd3, 50);
    test_random(4'd8, 45);

    item_ch.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d loads, %0d faces, %0d readouts, %0d clears", n_load, n_face,
             n_read, n_clear);
    $display("checked %0d gradient results over variable counts 0, 1, 3, 8 and 15",
             n_checked);
    if (errors == 0 && pending_grads.size() == 0) begin
      $display("PASS green_gauss_gradient_accumulator");
    end else begin
      $display("FAIL green_gauss_gradient_accumulator");
    end
    $finish;
  end

endmodule

`default_nettype wire
